// ===== rtl/eevt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eevt_pkg
// Shared types and codes of the encoder event value table.
// ----------------------------------------------------------------------------
package eevt_pkg;

    localparam int NUM_ENCODERS = 4;
    localparam int SLOTS        = 4;   // entries addressable by the 2-bit index

    // operations
    localparam logic [2:0] OP_SETUP = 3'd0;
    localparam logic [2:0] OP_EVENT = 3'd1;
    localparam logic [2:0] OP_MIDI  = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_EMPTY  = 3'd0;
    localparam logic [2:0] KIND_ROT    = 3'd1;
    localparam logic [2:0] KIND_SWITCH = 3'd2;
    localparam logic [2:0] KIND_MIDI   = 3'd3;
    localparam logic [2:0] KIND_SET    = 3'd4;
    localparam logic [2:0] KIND_READ   = 3'd5;
    localparam logic [2:0] KIND_SETUP  = 3'd6;
    localparam logic [2:0] KIND_REJECT = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic done;
    } t_seq_ctl;

    typedef struct packed {
        logic signed [15:0] mult;
        logic        [8:0]  factor;
        logic        [14:0] base;
        logic        [14:0] limit;
    } t_alu_in;

endpackage

// ===== rtl/eevt_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eevt_alu
// Shared multiply, add and clamp unit, one step per sequencer cycle.
// ----------------------------------------------------------------------------
module eevt_alu (
    input  logic                i_clk,
    input  eevt_pkg::t_seq_ctl  i_ctl,
    input  eevt_pkg::t_alu_in   i_opnd,
    output logic [14:0]         o_result
);
    import eevt_pkg::*;

    logic signed [24:0] r_prod;
    logic signed [24:0] n_prod;
    logic        [14:0] r_res;
    logic        [14:0] n_res;
    logic signed [25:0] sum;

    assign n_prod = i_opnd.mult * $signed({1'b0, i_opnd.factor});
    assign sum    = $signed({11'b0, i_opnd.base}) + 26'(r_prod);

    // clamp to 0..limit
    always_comb begin
        if (sum < 0) begin
            n_res = '0;
        end else if (sum > $signed({11'b0, i_opnd.limit})) begin
            n_res = i_opnd.limit;
        end else begin
            n_res = sum[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.acc_en) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

// ===== rtl/eevt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eevt_seq
// Sequencer stepping one item through multiply, accumulate and write back.
// ----------------------------------------------------------------------------
module eevt_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    output logic                o_busy,
    output eevt_pkg::t_seq_ctl  o_ctl
);
    import eevt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.mul_en = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_ctl.acc_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_ctl.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/encoder_event_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_event_value_table
// Table of rotary-encoder entries set up by setup and updated by events, MIDI changes and sets.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   The operation field picks setup, event byte decode, MIDI control change,
//   absolute set or read; the other input fields are used as that operation
//   needs them.
//   Every item gives exactly one result, shown on the o_ result ports for one
//   cycle while o_valid is high. The receiver has no stall; a result must be
//   captured in that cycle.
//   The result is registered on the ports after the accepted item has
//   passed the multiply, accumulate and done states. Busy is high in
//   these states, so a new item is only taken once the last one is done.
//   The steps come from the shared multiply/clamp unit: it multiplies,
//   then adds and clamps, and then the table and the result are written.
//   Reset clears the enable bits and values of all entries, the sequencer
//   and the result strobe; the other entry fields stay unknown until setup.
// ----------------------------------------------------------------------------
module encoder_event_value_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic [1:0]         i_entry,
    input  logic [7:0]         i_event_byte,
    input  logic [3:0]         i_midi_channel,
    input  logic [6:0]         i_midi_controller,
    input  logic [6:0]         i_midi_value,
    input  logic [14:0]        i_new_value,
    input  logic [14:0]        i_max_value,
    input  logic [7:0]         i_step,
    output logic               o_valid,
    output logic [2:0]         o_kind,
    output logic [1:0]         o_encoder,
    output logic [14:0]        o_value,
    output logic               o_hit,
    output logic               o_pressed,
    output logic signed [4:0]  o_delta,
    output logic [2:0]         o_match_count
);
    import eevt_pkg::*;

    t_seq_ctl seq_ctl;
    t_alu_in  alu_in;
    logic     accept;
    logic [14:0] alu_res;

    // latched item
    logic [2:0]  r_op;
    logic [1:0]  r_entry;
    logic [7:0]  r_ev;
    logic [3:0]  r_ch;
    logic [6:0]  r_ctl;
    logic [6:0]  r_mval;
    logic [14:0] r_nval;
    logic [14:0] r_maxv;
    logic [7:0]  r_step;

    // entry table
    logic        r_en   [SLOTS];
    logic [14:0] r_val  [SLOTS];
    logic [7:0]  r_stp  [SLOTS];
    logic [14:0] r_lim  [SLOTS];
    logic [3:0]  r_chn  [SLOTS];
    logic [6:0]  r_ctlr [SLOTS];

    // result registers
    logic        r_valid;
    logic [2:0]  r_kind,  n_kind;
    logic [1:0]  r_enc,   n_enc;
    logic [14:0] r_value, n_value;
    logic        r_hit,   n_hit;
    logic        r_press, n_press;
    logic [4:0]  r_delta, n_delta;
    logic [2:0]  r_cnt,   n_cnt;

    // table write controls
    logic              wr_entry;   // full setup of r_entry
    logic              wr_value;   // value write at tgt
    logic [SLOTS-1:0]  midi_match;

    logic [1:0]  tgt;
    logic        tgt_in_range;
    logic        entry_in_range;
    logic [7:0]  tgt_step;

    assign accept = start && !busy;

    eevt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .o_busy  (busy),
        .o_ctl   (seq_ctl)
    );

    eevt_alu u_alu (
        .i_clk    (i_clk),
        .i_ctl    (seq_ctl),
        .i_opnd   (alu_in),
        .o_result (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_entry <= i_entry;
            r_ev    <= i_event_byte;
            r_ch    <= i_midi_channel;
            r_ctl   <= i_midi_controller;
            r_mval  <= i_midi_value;
            r_nval  <= i_new_value;
            r_maxv  <= i_max_value;
            r_step  <= i_step;
        end
    end

    // event operations target the encoder in the event byte, every other operation the entry
    assign tgt            = (r_op == OP_EVENT) ? r_ev[6:5] : r_entry;
    assign tgt_in_range   = ({1'b0, tgt} < 3'(NUM_ENCODERS));
    assign entry_in_range = ({1'b0, r_entry} < 3'(NUM_ENCODERS));
    assign tgt_step       = r_stp[tgt];

    always_comb begin
        alu_in = '0;
        unique case (r_op)
            OP_SETUP: begin
                alu_in.mult   = $signed({1'b0, r_nval});
                alu_in.factor = 9'd1;
                alu_in.base   = '0;
                alu_in.limit  = r_maxv;
            end
            OP_EVENT: begin
                alu_in.mult   = 16'(signed'(r_ev[4:0]));
                alu_in.factor = (tgt_step == '0) ? 9'd1 : {1'b0, tgt_step};
                alu_in.base   = r_val[tgt];
                alu_in.limit  = r_lim[tgt];
            end
            default: begin
                alu_in.mult   = $signed({1'b0, r_nval});
                alu_in.factor = (tgt_step == '0) ? 9'd1 : {1'b0, tgt_step};
                alu_in.base   = '0;
                alu_in.limit  = r_lim[tgt];
            end
        endcase
    end

    always_comb begin
        midi_match = '0;
        n_cnt      = '0;
        for (int i = 0; i < SLOTS; i++) begin
            midi_match[i] = (i < NUM_ENCODERS) && r_en[i] && (r_chn[i] == r_ch)
                            && (r_ctlr[i] == r_ctl);
            n_cnt = n_cnt + 3'(midi_match[i]);
        end
    end

    always_comb begin
        n_kind   = KIND_REJECT;
        n_enc    = r_entry;
        n_value  = '0;
        n_hit    = 1'b0;
        n_press  = 1'b0;
        n_delta  = '0;
        wr_entry = 1'b0;
        wr_value = 1'b0;
        unique case (r_op)
            OP_SETUP: begin
                if (entry_in_range) begin
                    n_kind   = KIND_SETUP;
                    n_value  = alu_res;
                    n_hit    = 1'b1;
                    wr_entry = 1'b1;
                end
            end
            OP_EVENT: begin
                if (r_ev == '0) begin
                    n_kind = KIND_EMPTY;
                    n_enc  = '0;
                end else if (r_ev[7]) begin
                    n_kind  = KIND_SWITCH;
                    n_enc   = r_ev[2:1];
                    n_press = r_ev[0];
                end else begin
                    n_kind  = KIND_ROT;
                    n_enc   = r_ev[6:5];
                    n_delta = r_ev[4:0];
                    if (tgt_in_range) begin
                        if (r_en[tgt]) begin
                            n_value  = alu_res;
                            n_hit    = 1'b1;
                            wr_value = 1'b1;
                        end else begin
                            n_value = r_val[tgt];
                        end
                    end
                end
            end
            OP_MIDI: begin
                n_kind  = KIND_MIDI;
                n_value = {8'b0, r_mval};
                n_hit   = (n_cnt != '0);
                n_enc   = '0;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (midi_match[i]) begin
                        n_enc = 2'(i);
                    end
                end
            end
            OP_SET: begin
                if (entry_in_range && r_en[r_entry]) begin
                    n_kind   = KIND_SET;
                    n_value  = alu_res;
                    n_hit    = 1'b1;
                    wr_value = 1'b1;
                end
            end
            OP_READ: begin
                n_kind  = KIND_READ;
                n_value = entry_in_range ? r_val[r_entry] : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_en[i]  <= 1'b0;
                r_val[i] <= '0;
            end
        end else if (seq_ctl.done) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (r_op == OP_MIDI && midi_match[i]) begin
                    r_val[i] <= {8'b0, r_mval};
                end
            end
            if (wr_entry || wr_value) begin
                r_val[tgt] <= alu_res;
            end
            if (wr_entry) begin
                r_en[r_entry] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctl.done && wr_entry) begin
            r_stp[r_entry]  <= r_step;
            r_lim[r_entry]  <= r_maxv;
            r_chn[r_entry]  <= r_ch;
            r_ctlr[r_entry] <= r_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= seq_ctl.done;
        end
        if (seq_ctl.done) begin
            r_kind  <= n_kind;
            r_enc   <= n_enc;
            r_value <= n_value;
            r_hit   <= n_hit;
            r_press <= n_press;
            r_delta <= n_delta;
            r_cnt   <= (r_op == OP_MIDI) ? n_cnt : 3'd0;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_encoder     = r_enc;
    assign o_value       = r_value;
    assign o_hit         = r_hit;
    assign o_pressed     = r_press;
    assign o_delta       = signed'(r_delta);
    assign o_match_count = r_cnt;

endmodule

// ===== rtl/eevt_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eevt_check
// Port-level checks on handshake timing and result consistency.
// ----------------------------------------------------------------------------
module eevt_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_kind,
    input logic        o_hit,
    input logic [2:0]  o_match_count
);
    import eevt_pkg::*;

    // every accepted item gives its result once the sequencer has passed its multiply, accumulate and done states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result missing four cycles after accept");

    // a result is only shown once the sequencer is free again
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a midi hit goes with a nonzero match count and nothing else does
    a_midi_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_MIDI) |-> (o_hit == (o_match_count != 3'd0)))
        else $error("midi hit and match count disagree");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_REJECT) |-> (!o_hit && o_match_count == 3'd0))
        else $error("rejected item reports an update");

endmodule

bind encoder_event_value_table eevt_check u_eevt_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_kind        (o_kind),
    .o_hit         (o_hit),
    .o_match_count (o_match_count)
);
